@@ hdl/mlc_pkg.sv @@
// Shared types, constants and helpers for the multicolor Life cell rule unit.
package mlc_pkg;

    localparam int ROW_W      = 10;
    localparam int COL_W      = 10;
    localparam int CELL_W     = 4;
    localparam int SIDE_W     = 11;
    localparam int NBR_N      = 8;
    localparam int CNT_W      = 4;     // holds 0..8
    localparam int MAX_COLOR  = 15;
    localparam int LO_COLORS  = 8;     // colors 1..8 ranked in one group, 9..15 in the other
    localparam int CFG_IDX_W  = 2;
    localparam int SIDE_RESET = 1024;
    localparam int PIPE_DEPTH = 4;

    // neighbor slots
    localparam int NB_NW = 0;
    localparam int NB_N  = 1;
    localparam int NB_NE = 2;
    localparam int NB_W  = 3;
    localparam int NB_E  = 4;
    localparam int NB_SW = 5;
    localparam int NB_S  = 6;
    localparam int NB_SE = 7;

    typedef logic [CELL_W-1:0] cell_t;
    typedef logic [SIDE_W-1:0] side_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE = 2'd0,
        CFG_ROWS = 2'd1,
        CFG_COLS = 2'd2
    } cfg_idx_t;

    typedef enum logic {
        MODE_CLASSIC = 1'b0,
        MODE_COMPETE = 1'b1
    } mode_t;

    // after edge masking
    typedef struct packed {
        logic                    on_board;
        cell_t                   center;
        cell_t [NBR_N-1:0]       nbr;
    } mask_t;

    // after neighbor counting
    typedef struct packed {
        logic  on_board;
        cell_t center;
        cnt_t  live_cnt;
        cnt_t  same_cnt;
    } count_t;

    // after survival test and partial color ranking
    typedef struct packed {
        logic  on_board;
        cell_t center;
        logic  survive;
        logic  birth;
        cell_t best_lo;
        cnt_t  best_lo_n;
        cell_t best_hi;
        cnt_t  best_hi_n;
    } rank_t;

    function automatic cnt_t count_ones(input logic [NBR_N-1:0] bits);
        cnt_t acc;
        acc = '0;
        for (int i = 0; i < NBR_N; i++) begin
            acc = acc + cnt_t'(bits[i]);
        end
        return acc;
    endfunction

endpackage

@@ hdl/mlc_edge_mask.sv @@
// Stage 1: board edge test and masking of off-board neighbors.
module mlc_edge_mask (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [mlc_pkg::ROW_W-1:0]             row,
    input  logic [mlc_pkg::COL_W-1:0]             col,
    input  mlc_pkg::cell_t                        center,
    input  mlc_pkg::cell_t [mlc_pkg::NBR_N-1:0]   nbr,
    input  mlc_pkg::side_t                        rows_lim,
    input  mlc_pkg::side_t                        cols_lim,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output mlc_pkg::mask_t                        out_data
);
    import mlc_pkg::*;

    logic              valid_reg, valid_next;
    mask_t             data_reg, data_next;
    side_t             row_ext, col_ext;
    logic              up_ok, dn_ok, lf_ok, rt_ok;
    logic [NBR_N-1:0]  nbr_ok;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        row_ext = side_t'(row);
        col_ext = side_t'(col);
        up_ok   = (row != '0);
        dn_ok   = ((row_ext + side_t'(1)) < rows_lim);
        lf_ok   = (col != '0);
        rt_ok   = ((col_ext + side_t'(1)) < cols_lim);

        nbr_ok[NB_NW] = up_ok && lf_ok;
        nbr_ok[NB_N]  = up_ok;
        nbr_ok[NB_NE] = up_ok && rt_ok;
        nbr_ok[NB_W]  = lf_ok;
        nbr_ok[NB_E]  = rt_ok;
        nbr_ok[NB_SW] = dn_ok && lf_ok;
        nbr_ok[NB_S]  = dn_ok;
        nbr_ok[NB_SE] = dn_ok && rt_ok;

        data_next.on_board = (row_ext < rows_lim) && (col_ext < cols_lim);
        data_next.center   = data_next.on_board ? center : '0;
        for (int k = 0; k < NBR_N; k++) begin
            data_next.nbr[k] = (data_next.on_board && nbr_ok[k]) ? nbr[k] : '0;
        end

        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ hdl/mlc_tally.sv @@
// Stage 2: live, same-color and per-color neighbor counts.
module mlc_tally #(
    parameter int PLAYERS = 4
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  mlc_pkg::mask_t                            in_data,
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output mlc_pkg::count_t                           out_data,
    output logic [PLAYERS-1:0][mlc_pkg::CNT_W-1:0]    out_tally
);
    import mlc_pkg::*;

    logic                            valid_reg, valid_next;
    count_t                          data_reg, data_next;
    logic [PLAYERS-1:0][CNT_W-1:0]   tally_reg, tally_next;
    logic [NBR_N-1:0]                live, same;
    logic [PLAYERS-1:0][NBR_N-1:0]   hit;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        for (int k = 0; k < NBR_N; k++) begin
            live[k] = (in_data.nbr[k] != '0);
            same[k] = live[k] && (in_data.nbr[k] == in_data.center);
        end
        // color p+1 per tally slot p
        for (int p = 0; p < PLAYERS; p++) begin
            for (int k = 0; k < NBR_N; k++) begin
                hit[p][k] = (in_data.nbr[k] == CELL_W'(p + 1));
            end
            tally_next[p] = count_ones(hit[p]);
        end

        data_next.on_board = in_data.on_board;
        data_next.center   = in_data.center;
        data_next.live_cnt = count_ones(live);
        data_next.same_cnt = count_ones(same);

        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg  <= data_next;
            tally_reg <= tally_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_tally = tally_reg;

endmodule

@@ hdl/mlc_decide.sv @@
// Stages 3 and 4: survival test, birth color ranking and output register.
module mlc_decide #(
    parameter int PLAYERS = 4
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  mlc_pkg::mode_t                            mode,
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  mlc_pkg::count_t                           in_data,
    input  logic [PLAYERS-1:0][mlc_pkg::CNT_W-1:0]    in_tally,
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output mlc_pkg::cell_t                            out_cell
);
    import mlc_pkg::*;

    logic                              rank_valid_reg, rank_valid_next;
    rank_t                             rank_reg, rank_next;
    logic                              out_valid_reg, out_valid_next;
    cell_t                             cell_reg, cell_next;
    logic                              out_free;
    logic [MAX_COLOR-1:0][CNT_W-1:0]   tally_ext;
    logic signed [5:0]                 score;
    logic                              cls_ok, cmp_ok;

    // colors above PLAYERS never rank
    for (genvar g = 0; g < MAX_COLOR; g++) begin : g_ext
        if (g < PLAYERS) begin : g_used
            assign tally_ext[g] = in_tally[g];
        end else begin : g_zero
            assign tally_ext[g] = '0;
        end
    end

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = !rank_valid_reg || out_free;

    // stage 3
    always_comb begin
        // allies minus enemies = 2*same - live
        score  = $signed({1'b0, in_data.same_cnt, 1'b0}) - $signed({2'b00, in_data.live_cnt});
        cmp_ok = (score == 6'sd2) || (score == 6'sd3);
        cls_ok = (in_data.live_cnt == cnt_t'(2)) || (in_data.live_cnt == cnt_t'(3));

        rank_next.on_board = in_data.on_board;
        rank_next.center   = in_data.center;
        rank_next.survive  = (mode == MODE_COMPETE) ? cmp_ok : cls_ok;
        rank_next.birth    = (in_data.live_cnt == cnt_t'(3));

        // strict greater keeps the lowest color on ties
        rank_next.best_lo   = cell_t'(1);
        rank_next.best_lo_n = '0;
        for (int c = 1; c <= LO_COLORS; c++) begin
            if (tally_ext[c-1] > rank_next.best_lo_n) begin
                rank_next.best_lo   = cell_t'(c);
                rank_next.best_lo_n = tally_ext[c-1];
            end
        end
        rank_next.best_hi   = cell_t'(LO_COLORS + 1);
        rank_next.best_hi_n = '0;
        for (int c = LO_COLORS + 1; c <= MAX_COLOR; c++) begin
            if (tally_ext[c-1] > rank_next.best_hi_n) begin
                rank_next.best_hi   = cell_t'(c);
                rank_next.best_hi_n = tally_ext[c-1];
            end
        end

        rank_valid_next = in_ready ? in_valid : rank_valid_reg;
    end

    // stage 4
    always_comb begin
        cell_next = '0;
        if (rank_reg.on_board) begin
            if (rank_reg.center != '0) begin
                cell_next = rank_reg.survive ? rank_reg.center : '0;
            end else if (rank_reg.birth) begin
                cell_next = (rank_reg.best_hi_n > rank_reg.best_lo_n) ? rank_reg.best_hi
                                                                      : rank_reg.best_lo;
            end
        end
        out_valid_next = out_free ? rank_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rank_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            rank_valid_reg <= rank_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            rank_reg <= rank_next;
        end
        if (out_free && rank_valid_reg) begin
            cell_reg <= cell_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_cell  = cell_reg;

endmodule

@@ hdl/multicolor_life_cell_rule_unit.sv @@
// Top level of the multicolor Life cell rule unit: config registers and four-stage pipeline.
//
//  channel   direction  handshake           payload
//  cfg       in         cfg_wr_en           cfg_index, cfg_data
//  s_        in         s_valid / s_ready   s_row, s_col, s_center_cell, s_nbr_*
//  m_        out        m_valid / m_ready   m_next_cell
//
// One cell transaction per cycle sustained while m_ready stays high; each s_ transaction
// passes through the edge mask, counts, rank and output registers to m_valid.
// Every stage holds its own valid bit; a stage reloads when it is empty or its
// successor takes its contents, so bubbles collapse and a stalled m_ side
// backs pressure up stage by stage without dropping or duplicating transactions.
// Synchronous active-low reset clears the valid bits and sets mode to classic
// and both board sides to 1024 (clamped to MAX_SIDE).
// Board sizes are clamped to MAX_SIDE when written.
module multicolor_life_cell_rule_unit #(
    parameter int PLAYERS  = 4,
    parameter int MAX_SIDE = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [mlc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mlc_pkg::SIDE_W-1:0]        cfg_data,
    // cell input
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [mlc_pkg::ROW_W-1:0]         s_row,
    input  logic [mlc_pkg::COL_W-1:0]         s_col,
    input  mlc_pkg::cell_t                    s_center_cell,
    input  mlc_pkg::cell_t                    s_nbr_nw,
    input  mlc_pkg::cell_t                    s_nbr_n,
    input  mlc_pkg::cell_t                    s_nbr_ne,
    input  mlc_pkg::cell_t                    s_nbr_w,
    input  mlc_pkg::cell_t                    s_nbr_e,
    input  mlc_pkg::cell_t                    s_nbr_sw,
    input  mlc_pkg::cell_t                    s_nbr_s,
    input  mlc_pkg::cell_t                    s_nbr_se,
    // next-generation output
    output logic                              m_valid,
    input  logic                              m_ready,
    output mlc_pkg::cell_t                    m_next_cell
);
    import mlc_pkg::*;

    // Largest side the 11-bit registers can hold after clamping.
    localparam int    SIDE_CAP_INT = (MAX_SIDE > (1 << SIDE_W) - 1) ? (1 << SIDE_W) - 1
                                                                    : MAX_SIDE;
    localparam side_t SIDE_CAP     = side_t'(SIDE_CAP_INT);
    localparam side_t SIDE_INIT    = (SIDE_RESET > SIDE_CAP_INT) ? SIDE_CAP
                                                                 : side_t'(SIDE_RESET);

    mode_t   mode_reg, mode_next;
    side_t   rows_reg, rows_next;
    side_t   cols_reg, cols_next;
    side_t   side_wr;

    cell_t [NBR_N-1:0] nbr;

    logic    mask_valid, mask_ready;
    mask_t   mask_data;
    logic    cnt_valid, cnt_ready;
    count_t  cnt_data;
    logic [PLAYERS-1:0][CNT_W-1:0] cnt_tally;

    // ---------------------------------------------------------------
    // Configuration registers; writes to index 3 are dropped.
    // ---------------------------------------------------------------
    always_comb begin
        side_wr   = (cfg_data > SIDE_CAP) ? SIDE_CAP : cfg_data;
        mode_next = mode_reg;
        rows_next = rows_reg;
        cols_next = cols_reg;
        if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MODE: mode_next = mode_t'(cfg_data[0]);
                CFG_ROWS: rows_next = side_wr;
                CFG_COLS: cols_next = side_wr;
                default:  ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_CLASSIC;
            rows_reg <= SIDE_INIT;
            cols_reg <= SIDE_INIT;
        end else begin
            mode_reg <= mode_next;
            rows_reg <= rows_next;
            cols_reg <= cols_next;
        end
    end

    // ---------------------------------------------------------------
    // Pipeline
    // ---------------------------------------------------------------
    assign nbr[NB_NW] = s_nbr_nw;
    assign nbr[NB_N]  = s_nbr_n;
    assign nbr[NB_NE] = s_nbr_ne;
    assign nbr[NB_W]  = s_nbr_w;
    assign nbr[NB_E]  = s_nbr_e;
    assign nbr[NB_SW] = s_nbr_sw;
    assign nbr[NB_S]  = s_nbr_s;
    assign nbr[NB_SE] = s_nbr_se;

    // stage 1: off-board cells and neighbors forced dead
    mlc_edge_mask u_mask (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .row       (s_row),
        .col       (s_col),
        .center    (s_center_cell),
        .nbr       (nbr),
        .rows_lim  (rows_reg),
        .cols_lim  (cols_reg),
        .out_valid (mask_valid),
        .out_ready (mask_ready),
        .out_data  (mask_data)
    );

    // stage 2: neighbor counts
    mlc_tally #(
        .PLAYERS (PLAYERS)
    ) u_tally (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mask_valid),
        .in_ready  (mask_ready),
        .in_data   (mask_data),
        .out_valid (cnt_valid),
        .out_ready (cnt_ready),
        .out_data  (cnt_data),
        .out_tally (cnt_tally)
    );

    // stages 3-4: rule evaluation and output register
    mlc_decide #(
        .PLAYERS (PLAYERS)
    ) u_decide (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .mode      (mode_reg),
        .in_valid  (cnt_valid),
        .in_ready  (cnt_ready),
        .in_data   (cnt_data),
        .in_tally  (cnt_tally),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_cell  (m_next_cell)
    );

endmodule

@@ hdl/mlc_checker.sv @@
// Port-level assertions for the multicolor Life cell rule unit, with bind.
module mlc_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input logic           m_valid,
    input logic           m_ready,
    input mlc_pkg::cell_t m_next_cell
);
    import mlc_pkg::*;

    logic [2:0] inflight_reg, inflight_next;

    always_comb begin
        inflight_next = inflight_reg + 3'(s_valid && s_ready) - 3'(m_valid && m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_next_cell))
        else $error("m_ side result changed under stall");

    // no result without a transaction in flight
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> inflight_reg != 3'd0)
        else $error("result with nothing in flight");

    // never more transactions in flight than pipeline stages
    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= 3'(PIPE_DEPTH))
        else $error("pipeline holds too many transactions");

    // an empty output register means the input side can take a transaction
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // with m_ready held high, an accepted transaction reaches m_valid
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) ##1 m_ready ##1 m_ready ##1 m_ready |=> m_valid)
        else $error("result late on an open output");

endmodule

bind multicolor_life_cell_rule_unit mlc_checker u_mlc_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_next_cell (m_next_cell)
);

@@ dv/multicolor_life_cell_rule_unit_test.sv @@
// Self-checking testbench for the multicolor Life cell rule unit.
`timescale 1ns / 100ps

module multicolor_life_cell_rule_unit_test;
    import mlc_pkg::*;

    localparam int PLAYERS     = 4;
    localparam int MAX_SIDE    = 1024;
    localparam int QUIET_LIMIT = 2000;   // cycles with no transaction anywhere
    localparam int PRINT_CAP   = 40;     // mismatch lines printed before going silent
    localparam int PHASES      = 11;
    localparam int PHASE_CELLS = 150;

    // index just past the register list; the block must ignore writes to it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef enum {
        OP_CELL,    // one cell transaction on s_
        OP_CFG,     // one register write, issued only with the pipeline empty
        OP_DRAIN    // hold the sender until every pending result is back
    } op_kind_t;

    typedef struct {
        op_kind_t              kind;
        logic [ROW_W-1:0]      row;
        logic [COL_W-1:0]      col;
        cell_t                 center;
        cell_t [NBR_N-1:0]     nbr;      // slot order from the package (NB_NW .. NB_SE)
        logic [CFG_IDX_W-1:0]  idx;
        side_t                 data;
    } board_op_t;

    // ------------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ------------------------------------------------------------------
    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    side_t                 cfg_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [ROW_W-1:0]      s_row = '0;
    logic [COL_W-1:0]      s_col = '0;
    cell_t                 s_center_cell = '0;
    cell_t                 s_nbr_nw = '0, s_nbr_n = '0, s_nbr_ne = '0, s_nbr_w = '0;
    cell_t                 s_nbr_e = '0, s_nbr_sw = '0, s_nbr_s = '0, s_nbr_se = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    cell_t                 m_next_cell;

    multicolor_life_cell_rule_unit #(
        .PLAYERS  (PLAYERS),
        .MAX_SIDE (MAX_SIDE)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_row         (s_row),
        .s_col         (s_col),
        .s_center_cell (s_center_cell),
        .s_nbr_nw      (s_nbr_nw),
        .s_nbr_n       (s_nbr_n),
        .s_nbr_ne      (s_nbr_ne),
        .s_nbr_w       (s_nbr_w),
        .s_nbr_e       (s_nbr_e),
        .s_nbr_sw      (s_nbr_sw),
        .s_nbr_s       (s_nbr_s),
        .s_nbr_se      (s_nbr_se),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_next_cell   (m_next_cell)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Shared testbench state
    // ------------------------------------------------------------------
    board_op_t   ops_to_send[$];     // filled once by the stimulus block
    cell_t       next_cells_due[$];  // predicted results, oldest first
    board_op_t   on_wire;            // cell transaction currently offered on s_

    // our own copy of the register file, updated when a write is issued
    mode_t       rule_mode = MODE_CLASSIC;
    side_t       board_rows = side_t'(SIDE_RESET);
    side_t       board_cols = side_t'(SIDE_RESET);

    int          mismatches = 0;
    int          cells_checked = 0;
    int          births = 0;
    int          survivals = 0;
    int          reg_writes = 0;
    int          settings = 0;
    int          cycle_no = 0;
    int          quiet = 0;
    int          send_gap = 0;
    int          recv_stall = 0;

    task automatic report(input string what, input int got, input int want);
        if (mismatches < PRINT_CAP)
            $display("%0t mismatch: %s (got %0d, expected %0d)", $realtime, what, got, want);
        mismatches++;
    endtask

    // Gap length for both sides: mostly zero or short, now and then long.
    // Periodically there is a calm stretch with no gaps at all.
    function automatic int pick_gap();
        int r;
        if ((cycle_no % 700) < 150)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // ------------------------------------------------------------------
    // Next-generation predictor
    // ------------------------------------------------------------------
    function automatic cell_t next_generation(input board_op_t c);
        int dr[NBR_N] = '{-1, -1, -1, 0, 0, 1, 1, 1};
        int dc[NBR_N] = '{-1, 0, 1, -1, 1, -1, 0, 1};
        int tally[PLAYERS+1];
        int nrows, ncols, r, q, live, score, n, best, best_n;
        cell_t v;
        // oversized boards behave as the largest one
        nrows = (board_rows > MAX_SIDE) ? MAX_SIDE : int'(board_rows);
        ncols = (board_cols > MAX_SIDE) ? MAX_SIDE : int'(board_cols);
        if (int'(c.row) >= nrows || int'(c.col) >= ncols)
            return '0;
        live  = 0;
        score = 0;
        for (int p = 0; p <= PLAYERS; p++)
            tally[p] = 0;
        for (int k = 0; k < NBR_N; k++) begin
            r = int'(c.row) + dr[k];
            q = int'(c.col) + dc[k];
            v = c.nbr[k];
            // off-board neighbors are dead whatever their value
            if (r < 0 || q < 0 || r >= nrows || q >= ncols || v == '0)
                continue;
            live++;
            score += (v == c.center) ? 1 : -1;
            if (int'(v) <= PLAYERS)
                tally[v]++;
        end
        if (c.center != '0) begin
            n = (rule_mode == MODE_COMPETE) ? score : live;
            return (n == 2 || n == 3) ? c.center : cell_t'(0);
        end
        if (live != 3)
            return '0;
        // birth color: most common player color, lowest wins a tie, 1 by default
        best   = 1;
        best_n = 0;
        for (int p = 1; p <= PLAYERS; p++) begin
            if (tally[p] > best_n) begin
                best_n = tally[p];
                best   = p;
            end
        end
        return cell_t'(best);
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers cell transactions and issues register writes.
    // Writes and explicit drains wait until no result is outstanding.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : driver
        board_op_t nxt;
        logic      valid_n;
        logic      wr_n;
        cell_t     want;
        if (!aresetn) begin
            s_valid   <= 1'b0;
            cfg_wr_en <= 1'b0;
            send_gap  = 0;
        end else begin
            valid_n = s_valid;
            wr_n    = 1'b0;
            if (s_valid && s_ready) begin
                want = next_generation(on_wire);
                next_cells_due.push_back(want);
                if (want != '0 && on_wire.center == '0)
                    births++;
                if (want != '0 && on_wire.center != '0)
                    survivals++;
                valid_n  = 1'b0;
                send_gap = pick_gap();
            end
            if (!valid_n) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (ops_to_send.size() != 0) begin
                    nxt = ops_to_send[0];
                    unique case (nxt.kind)
                        OP_CELL: begin
                            void'(ops_to_send.pop_front());
                            on_wire       = nxt;
                            s_row         <= nxt.row;
                            s_col         <= nxt.col;
                            s_center_cell <= nxt.center;
                            s_nbr_nw      <= nxt.nbr[NB_NW];
                            s_nbr_n       <= nxt.nbr[NB_N];
                            s_nbr_ne      <= nxt.nbr[NB_NE];
                            s_nbr_w       <= nxt.nbr[NB_W];
                            s_nbr_e       <= nxt.nbr[NB_E];
                            s_nbr_sw      <= nxt.nbr[NB_SW];
                            s_nbr_s       <= nxt.nbr[NB_S];
                            s_nbr_se      <= nxt.nbr[NB_SE];
                            valid_n       = 1'b1;
                        end
                        OP_CFG: begin
                            if (next_cells_due.size() == 0) begin
                                void'(ops_to_send.pop_front());
                                cfg_index <= nxt.idx;
                                cfg_data  <= nxt.data;
                                wr_n      = 1'b1;
                                reg_writes++;
                                unique case (cfg_idx_t'(nxt.idx))
                                    CFG_MODE: rule_mode  = mode_t'(nxt.data[0]);
                                    CFG_ROWS: board_rows = nxt.data;
                                    CFG_COLS: board_cols = nxt.data;
                                    default: ;
                                endcase
                            end
                        end
                        default: begin
                            if (next_cells_due.size() == 0)
                                void'(ops_to_send.pop_front());
                        end
                    endcase
                end
            end
            s_valid   <= valid_n;
            cfg_wr_en <= wr_n;
        end
    end

    // ------------------------------------------------------------------
    // Result side: random back-pressure, then compare each transaction
    // against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : recv_side
        if (!aresetn) begin
            m_ready    <= 1'b0;
            recv_stall = 0;
        end else if (recv_stall > 0) begin
            recv_stall--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                recv_stall = pick_gap();
        end
    end

    always @(posedge aclk) begin : result_check
        cell_t want;
        if (aresetn && m_valid && m_ready) begin
            if (next_cells_due.size() == 0) begin
                report("result with nothing outstanding", int'(m_next_cell), 0);
            end else begin
                want = next_cells_due.pop_front();
                cells_checked++;
                if (m_next_cell !== want)
                    report("next_cell", int'(m_next_cell), int'(want));
            end
        end
    end

    // Watchdog: any transaction or register write keeps it quiet.
    always @(posedge aclk) begin : watchdog
        cycle_no++;
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                         quiet, next_cells_due.size());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    function automatic logic [NBR_N*CELL_W-1:0] ring(
        input cell_t nw, input cell_t n, input cell_t ne, input cell_t w,
        input cell_t e, input cell_t sw, input cell_t s, input cell_t se);
        return {se, s, sw, e, w, ne, n, nw};
    endfunction

    task automatic add_cell(input int row, input int col, input cell_t center,
                            input logic [NBR_N*CELL_W-1:0] nbr);
        board_op_t op;
        op.kind   = OP_CELL;
        op.row    = row[ROW_W-1:0];
        op.col    = col[COL_W-1:0];
        op.center = center;
        op.nbr    = nbr;
        ops_to_send.push_back(op);
    endtask

    task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input side_t data);
        board_op_t op;
        op.kind = OP_CFG;
        op.idx  = idx;
        op.data = data;
        ops_to_send.push_back(op);
    endtask

    task automatic add_drain();
        board_op_t op;
        op.kind = OP_DRAIN;
        ops_to_send.push_back(op);
    endtask

    // full register set; upper mode bits are junk the block must ignore
    task automatic add_setting(input mode_t mode, input int rows, input int cols);
        side_t junk;
        junk = side_t'($urandom);
        add_drain();
        add_write(CFG_MODE, {junk[SIDE_W-1:1], mode});
        add_write(CFG_ROWS, side_t'(rows));
        add_write(CFG_COLS, side_t'(cols));
        settings++;
    endtask

    // position biased toward the board edges and just past them
    function automatic int pick_pos(input int side);
        int r;
        r = $urandom_range(0, 9);
        if (side == 0 || r == 0)
            return $urandom_range(0, 1023);
        if (r < 3)
            return $urandom_range(0, 1) ? 0 : side - 1;
        if (r == 3)
            return (side >= MAX_SIDE) ? MAX_SIDE - 1 : side;
        return $urandom_range(0, side - 1);
    endfunction

    function automatic cell_t pick_color();
        if ($urandom_range(0, 99) < 85)
            return cell_t'($urandom_range(1, PLAYERS));
        return cell_t'($urandom_range(PLAYERS + 1, MAX_COLOR));
    endfunction

    task automatic add_random_cell(input int rows, input int cols);
        logic [NBR_N*CELL_W-1:0] nbr;
        cell_t own, center;
        int    density;
        if ($urandom_range(0, 9) == 0) begin
            // unconstrained noise: every bit of every field
            add_cell($urandom_range(0, 1023), $urandom_range(0, 1023),
                     cell_t'($urandom), $urandom);
        end else begin
            // a dominant color so ally counts and birth majorities show up
            own     = pick_color();
            center  = ($urandom_range(0, 1) == 0) ? cell_t'(0)
                    : ($urandom_range(0, 4) == 0) ? pick_color() : own;
            density = $urandom_range(15, 60);
            for (int k = 0; k < NBR_N; k++) begin
                if ($urandom_range(0, 99) < density)
                    nbr[k*CELL_W +: CELL_W] = ($urandom_range(0, 1) == 0) ? own : pick_color();
                else
                    nbr[k*CELL_W +: CELL_W] = '0;
            end
            add_cell(pick_pos(rows), pick_pos(cols), center, nbr);
        end
    endtask

    function automatic int pick_side();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 0;
        if (r < 4)
            return $urandom_range(1, 3);
        if (r < 6)
            return MAX_SIDE;
        if (r == 6)
            return $urandom_range(MAX_SIDE + 1, 2047);
        if (r < 16)
            return $urandom_range(4, 40);
        return $urandom_range(1, MAX_SIDE);
    endfunction

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : sequence_main
        int rows, cols;
        mode_t mode;

        // -- directed: reset settings, classic rule, full 1024x1024 board --
        // corners: only the on-board neighbors may count
        add_cell(0, 0, 4'd1, {NBR_N{4'd1}});            // three live, survives
        add_cell(1023, 1023, 4'd0, {NBR_N{4'd15}});     // birth from foreign colors -> 1
        add_cell(0, 1023, 4'd2, {NBR_N{4'd2}});
        add_cell(1023, 0, 4'd0, '0);
        // birth majority, tie to the lowest color
        add_cell(500, 500, 4'd0, ring(4'd2, 4'd0, 4'd0, 4'd2, 4'd0, 4'd0, 4'd3, 4'd0));
        add_cell(10, 10, 4'd0, ring(4'd3, 4'd1, 4'd2, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0));
        add_cell(10, 10, 4'd0, ring(4'd4, 4'd4, 4'd9, 4'd1, 4'd0, 4'd0, 4'd0, 4'd0));
        add_cell(10, 10, 4'd0, ring(4'd0, 4'd0, 4'd0, 4'd0, 4'd12, 4'd13, 4'd14, 4'd0));
        // survival counts 1, 2 and 4
        add_cell(10, 10, 4'd3, ring(4'd3, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0));
        add_cell(10, 10, 4'd3, ring(4'd3, 4'd1, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0));
        add_cell(10, 10, 4'd3, ring(4'd3, 4'd1, 4'd2, 4'd4, 4'd0, 4'd0, 4'd0, 4'd0));
        // color above the player range keeps its color when it survives
        add_cell(10, 10, 4'd15, ring(4'd0, 4'd0, 4'd0, 4'd15, 4'd1, 4'd0, 4'd0, 4'd0));

        // -- competition on a 5x7 board --
        add_setting(MODE_COMPETE, 5, 7);
        add_cell(4, 6, 4'd1, {NBR_N{4'd1}});            // corner, three allies
        add_cell(2, 3, 4'd1, ring(4'd1, 4'd1, 4'd2, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0));
        add_cell(2, 3, 4'd1, ring(4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd2, 4'd0, 4'd0));
        add_cell(2, 3, 4'd2, {NBR_N{4'd2}});            // eight allies, overcrowded
        add_cell(5, 3, 4'd0, ring(4'd1, 4'd1, 4'd1, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0));
        add_cell(2, 7, 4'd0, ring(4'd1, 4'd1, 4'd1, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0));
        add_cell(2, 3, 4'd0, ring(4'd4, 4'd0, 4'd4, 4'd0, 4'd0, 4'd4, 4'd0, 4'd0));
        // write past the register list: nothing may change
        add_drain();
        add_write(CFG_SPARE, '0);
        add_cell(4, 6, 4'd1, {NBR_N{4'd1}});
        // empty board, then oversized board clamped, then the smallest board
        add_setting(MODE_CLASSIC, 0, 7);
        add_cell(0, 0, 4'd0, ring(4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd0, 4'd1, 4'd1));
        add_setting(MODE_CLASSIC, 2047, 1025);
        add_cell(1023, 1023, 4'd0, {NBR_N{4'd15}});
        add_setting(MODE_COMPETE, 1, 1);
        add_cell(0, 0, 4'd3, {NBR_N{4'd3}});
        add_cell(0, 0, 4'd0, {NBR_N{4'd1}});

        // -- random phases, each under its own register setting --
        for (int ph = 0; ph < PHASES; ph++) begin
            rows = pick_side();
            cols = pick_side();
            mode = ($urandom_range(0, 1) == 0) ? MODE_CLASSIC : MODE_COMPETE;
            if (ph == PHASES - 1) begin
                rows = MAX_SIDE;    // finish on the largest board
                cols = MAX_SIDE;
            end
            add_setting(mode, rows, cols);
            if ($urandom_range(0, 2) == 0)
                add_write(CFG_SPARE, side_t'($urandom));
            for (int i = 0; i < PHASE_CELLS; i++) begin
                add_random_cell((rows > MAX_SIDE) ? MAX_SIDE : rows,
                                (cols > MAX_SIDE) ? MAX_SIDE : cols);
                if (ph == 2 && i == PHASE_CELLS / 2)
                    add_drain();    // sender holds mid-stream until the pipe empties
            end
        end

        // single reset at the start of the run
        aresetn = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // wait for the last transaction and every result, then let the pipeline settle
        while (ops_to_send.size() != 0 || s_valid || next_cells_due.size() != 0)
            @(posedge aclk);
        repeat (4 * PIPE_DEPTH) @(posedge aclk);

        $display("covered %0d cells (%0d births, %0d survivals) under %0d register settings",
                 cells_checked, births, survivals, settings);
        $display("%0d register writes, %0d mismatches", reg_writes, mismatches);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/mlc_pkg.sv
hdl/mlc_edge_mask.sv
hdl/mlc_tally.sv
hdl/mlc_decide.sv
hdl/multicolor_life_cell_rule_unit.sv
hdl/mlc_checker.sv
dv/multicolor_life_cell_rule_unit_test.sv
